@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top-level core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/iapt_pkg.sv @@
// Shared widths, register indexes and types of the inverse affine point transform.
package iapt_pkg;

  localparam int CoefW  = 18;            // Q2.16 matrix entry
  localparam int AdjW   = 38;            // adjugate entry
  localparam int DetW   = 56;            // determinant
  localparam int SoW    = 48;            // scaled offset
  localparam int DiffW  = 49;            // point minus scaled offset
  localparam int LoW    = 25;            // unsigned low slice of the difference
  localparam int HiW    = DiffW - LoW;   // signed high slice
  localparam int PlW    = AdjW + LoW + 1;
  localparam int PhW    = AdjW + HiW;
  localparam int SumLW  = PlW + 2;
  localparam int SumHW  = PhW + 2;
  localparam int AccW   = 89;
  localparam int QW     = 32;
  localparam int CfgW   = 54;
  localparam int CfgIdxW = 3;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [CfgIdxW-1:0] REG_ROW0   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROW1   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROW2   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OFF_X  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OFF_Y  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OFF_Z  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SCALE  = 3'd6;

  localparam logic [15:0] ScaleReset = 16'd1000;

  typedef struct packed {
    logic [8:0][AdjW-1:0] adj;
    logic [DetW-1:0]      det_mag;
    logic                 det_neg;
    logic                 singular;
  } coef_t;

  typedef struct packed {
    logic [2:0][DiffW-1:0] diff;
    logic                  last;
  } item_t;

endpackage

@@ hw/rtl/iapt_front.sv @@
// Front end: configuration registers, inverse preparation and point intake.
module iapt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [iapt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [iapt_pkg::CfgW-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [31:0]             in_point_x,
  input  logic signed [31:0]             in_point_y,
  input  logic signed [31:0]             in_point_z,
  input  logic                           in_last_point,
  output logic                           q_push,
  output iapt_pkg::item_t                q_item,
  input  logic                           q_full,
  output iapt_pkg::coef_t                coef
);
  import iapt_pkg::*;

  typedef enum logic [5:0] {
    ST_MUL   = 6'b000001,
    ST_ADJ   = 6'b000010,
    ST_DMUL  = 6'b000100,
    ST_DSUM  = 6'b001000,
    ST_DMAG  = 6'b010000,
    ST_READY = 6'b100000
  } prep_state_t;

  prep_state_t state_r, state_nxt;

  logic [CfgW-1:0]          row_r [3];
  logic signed [31:0]       off_r [3];
  logic [15:0]              scale_r;

  logic signed [2*CoefW-1:0] pa_r [9], pa_nxt [9];
  logic signed [2*CoefW-1:0] pb_r [9], pb_nxt [9];
  logic signed [SoW-1:0]     so_r [3], so_nxt [3];
  logic signed [AdjW-1:0]    adj_r [9];
  logic signed [DetW-1:0]    dp_r [3], dp_nxt [3];
  logic signed [DetW-1:0]    det_r;
  logic [DetW-1:0]           det_mag_r;
  logic                      det_neg_r;
  logic                      sing_r;
  logic signed [31:0]        pt [3];

  function automatic logic signed [CoefW-1:0] ent(input logic [CfgW-1:0] row, input int col);
    return $signed(row[CoefW*col +: CoefW]);
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        row_r[k] <= '0;
        off_r[k] <= '0;
      end
      scale_r <= ScaleReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0:  row_r[0] <= cfg_wdata;
        REG_ROW1:  row_r[1] <= cfg_wdata;
        REG_ROW2:  row_r[2] <= cfg_wdata;
        REG_OFF_X: off_r[0] <= $signed(cfg_wdata[31:0]);
        REG_OFF_Y: off_r[1] <= $signed(cfg_wdata[31:0]);
        REG_OFF_Z: off_r[2] <= $signed(cfg_wdata[31:0]);
        REG_SCALE: scale_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // preparation sequencer; any register write restarts it
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_MUL:   state_nxt = ST_ADJ;
      ST_ADJ:   state_nxt = ST_DMUL;
      ST_DMUL:  state_nxt = ST_DSUM;
      ST_DSUM:  state_nxt = ST_DMAG;
      ST_DMAG:  state_nxt = ST_READY;
      ST_READY: state_nxt = ST_READY;
      default:  state_nxt = ST_MUL;
    endcase
    if (cfg_we && (cfg_index inside {[REG_ROW0:REG_SCALE]})) state_nxt = ST_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_MUL;
    else        state_r <= state_nxt;
  end

  // cofactor products, scaled offset, adjugate, determinant and its magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pa_nxt[i*3+j] = ent(row_r[(j+1)%3], (i+1)%3) * ent(row_r[(j+2)%3], (i+2)%3);
        pb_nxt[i*3+j] = ent(row_r[(j+1)%3], (i+2)%3) * ent(row_r[(j+2)%3], (i+1)%3);
      end
    end
    for (int k = 0; k < 3; k++) begin
      so_nxt[k] = off_r[k] * $signed({1'b0, scale_r});
      dp_nxt[k] = ent(row_r[0], k) * adj_r[3*k];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      so_r <= so_nxt;
    end
    if (state_r == ST_ADJ) begin
      for (int k = 0; k < 9; k++) adj_r[k] <= AdjW'(pa_r[k]) - AdjW'(pb_r[k]);
    end
    if (state_r == ST_DMUL) dp_r <= dp_nxt;
    if (state_r == ST_DSUM) det_r <= dp_r[0] + dp_r[1] + dp_r[2];
    if (state_r == ST_DMAG) begin
      det_mag_r <= det_r[DetW-1] ? DetW'(-det_r) : DetW'(det_r);
      det_neg_r <= det_r[DetW-1];
      sing_r    <= (det_r == '0);
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) coef.adj[k] = adj_r[k];
    coef.det_mag  = det_mag_r;
    coef.det_neg  = det_neg_r;
    coef.singular = sing_r;
  end

  // intake: difference in Q33.16
  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  assign in_stall = (state_r != ST_READY) || q_full;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q_item.diff[k] = DiffW'($signed({pt[k], 16'h0000})) - DiffW'(so_r[k]);
    end
    q_item.last = in_last_point;
  end

endmodule

@@ hw/rtl/iapt_queue.sv @@
// Short queue between front end and arithmetic back end.
module iapt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  iapt_pkg::item_t item_in,
  output logic            full,
  input  logic            pop,
  output iapt_pkg::item_t item_out,
  output logic            empty
);
  import iapt_pkg::*;

  item_t            mem_r [QDepth];
  logic [QPtrW-1:0] wr_r, rd_r;
  logic [QPtrW:0]   cnt_r;

  assign full     = (cnt_r == (QPtrW+1)'(QDepth));
  assign empty    = (cnt_r == '0);
  assign item_out = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ hw/rtl/iapt_back.sv @@
// Back end: adjugate products, sums and pipelined division by the determinant.
module iapt_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  iapt_pkg::coef_t         coef,
  input  iapt_pkg::item_t         q_item,
  input  logic                    q_empty,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [31:0]      out_orig_x,
  output logic signed [31:0]      out_orig_y,
  output logic signed [31:0]      out_orig_z,
  output logic                    out_singular,
  output logic                    out_saturated,
  output logic                    out_last_out
);
  import iapt_pkg::*;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r;
  logic l1_r, l2_r, l3_r, l4_r;
  logic [QW:0] vd_r, ld_r;
  logic out_valid_r;

  logic signed [PlW-1:0]   pl_r [9];
  logic signed [PhW-1:0]   ph_r [9];
  logic signed [SumLW-1:0] sl_r [3];
  logic signed [SumHW-1:0] sh_r [3];
  logic signed [AccW-1:0]  acc_r [3];
  logic [AccW-1:0]         mag_r [3];
  logic [2:0]              neg4_r;

  // divider state per stage and lane
  logic [DetW-1:0] rem_r [QW+1][3];
  logic [QW-1:0]   lo_r  [QW+1][3];
  logic [QW-1:0]   q_r   [QW+1][3];
  logic            neg_r [QW+1][3];
  logic            big_r [QW+1][3];

  logic signed [31:0] res [3];
  logic [2:0]         clip;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic               sing_o_r, sat_o_r, last_o_r;

  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && !q_empty;

  // valid and last chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      vd_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= q_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vd_r <= {vd_r[QW-1:0], v4_r};
      out_valid_r <= vd_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_r <= q_item.last;
      l2_r <= l1_r;
      l3_r <= l2_r;
      l4_r <= l3_r;
      ld_r <= {ld_r[QW-1:0], l4_r};
    end
  end

  // products, sums, recombination, magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pl_r[i*3+j] <= $signed(coef.adj[i*3+j]) *
                         $signed({1'b0, q_item.diff[j][LoW-1:0]});
          ph_r[i*3+j] <= $signed(coef.adj[i*3+j]) *
                         $signed(q_item.diff[j][DiffW-1:LoW]);
        end
        sl_r[i]  <= SumLW'(pl_r[i*3]) + SumLW'(pl_r[i*3+1]) + SumLW'(pl_r[i*3+2]);
        sh_r[i]  <= SumHW'(ph_r[i*3]) + SumHW'(ph_r[i*3+1]) + SumHW'(ph_r[i*3+2]);
        acc_r[i] <= (AccW'(sh_r[i]) <<< LoW) + AccW'(sl_r[i]);
        mag_r[i] <= acc_r[i][AccW-1] ? AccW'(-acc_r[i]) : AccW'(acc_r[i]);
        neg4_r[i] <= acc_r[i][AccW-1] ^ coef.det_neg;
      end
    end
  end

  // overflow check and divider entry: the high part must stay below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        big_r[0][i] <= (mag_r[i][AccW-1:QW] >= {1'b0, coef.det_mag});
        rem_r[0][i] <= mag_r[i][QW +: DetW];
        lo_r[0][i]  <= mag_r[i][QW-1:0];
        q_r[0][i]   <= '0;
        neg_r[0][i] <= neg4_r[i];
      end
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < QW; s++) begin : g_div
    logic [DetW:0] t [3];
    logic          ge [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {rem_r[s][i], lo_r[s][i][QW-1]};
        ge[i] = (t[i] >= {1'b0, coef.det_mag});
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          rem_r[s+1][i] <= ge[i] ? DetW'(t[i] - {1'b0, coef.det_mag}) : t[i][DetW-1:0];
          lo_r[s+1][i]  <= {lo_r[s][i][QW-2:0], 1'b0};
          q_r[s+1][i]   <= {q_r[s][i][QW-2:0], ge[i]};
          neg_r[s+1][i] <= neg_r[s][i];
          big_r[s+1][i] <= big_r[s][i];
        end
      end
    end
  end

  // sign, saturation and singular masking
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (neg_r[QW][i]) begin
        clip[i] = big_r[QW][i] || (q_r[QW][i][QW-1] && (|q_r[QW][i][QW-2:0]));
        res[i]  = clip[i] ? 32'sh8000_0000 : -$signed(q_r[QW][i]);
      end else begin
        clip[i] = big_r[QW][i] || q_r[QW][i][QW-1];
        res[i]  = clip[i] ? 32'sh7FFF_FFFF : $signed(q_r[QW][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r     <= coef.singular ? '0 : res[0];
      oy_r     <= coef.singular ? '0 : res[1];
      oz_r     <= coef.singular ? '0 : res[2];
      sing_o_r <= coef.singular;
      sat_o_r  <= !coef.singular && (|clip);
      last_o_r <= ld_r[QW];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_orig_x    = ox_r;
  assign out_orig_y    = oy_r;
  assign out_orig_z    = oz_r;
  assign out_singular  = sing_o_r;
  assign out_saturated = sat_o_r;
  assign out_last_out  = last_o_r;

endmodule

@@ hw/rtl/inverse_affine_point_transform_core.sv @@
// Inverse affine point transform: recovers X1 = R^-1 * (X2 - V*scale) for one
// integer 3D point per clock when not stalled. After reset or any register
// write the front end forms the scaled offset, adjugate, determinant and its
// magnitude in turn, with in_stall held high; after that it takes one point
// every cycle while the queue is not full. Each point passes a short queue and
// then a 38-stage back end (products, sums, recombination, magnitude, an
// overflow check, a 32-stage one-bit-per-stage divider per axis and the output
// register), and sustained rate is one transfer per cycle while out_stall is
// low. The whole back end holds in place while a finished result waits on
// out_stall; the queue keeps taking points until it is full. A zero
// determinant gives zero outputs with singular set.
`include "assert_macros.svh"

module inverse_affine_point_transform_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [iapt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [iapt_pkg::CfgW-1:0]     cfg_wdata,
  // points in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_point_x,
  input  logic signed [31:0]            in_point_y,
  input  logic signed [31:0]            in_point_z,
  input  logic                          in_last_point,
  // results out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_orig_x,
  output logic signed [31:0]            out_orig_y,
  output logic signed [31:0]            out_orig_z,
  output logic                          out_singular,
  output logic                          out_saturated,
  output logic                          out_last_out
);
  import iapt_pkg::*;

  coef_t coef;
  item_t q_in, q_out;
  logic  q_push, q_pop, q_full, q_empty;

  // front end: config, preparation, intake
  iapt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .in_last_point (in_last_point),
    .q_push        (q_push),
    .q_item        (q_in),
    .q_full        (q_full),
    .coef          (coef)
  );

  // decoupling queue
  iapt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .item_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .item_out (q_out),
    .empty    (q_empty)
  );

  // back end: arithmetic pipeline and output register
  iapt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .coef          (coef),
    .q_item        (q_out),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_orig_x    (out_orig_x),
    .out_orig_y    (out_orig_y),
    .out_orig_z    (out_orig_z),
    .out_singular  (out_singular),
    .out_saturated (out_saturated),
    .out_last_out  (out_last_out)
  );

  // a register write always reopens preparation, so intake must close
  `ASSERT_NXT(a_cfg_blocks_intake, clk, rst_n, cfg_we && (cfg_index <= REG_SCALE), in_stall, "intake open right after a register write")
  // singular results carry zero coordinates and no clip
  `ASSERT_IMP(a_singular_zero, clk, rst_n, out_valid && out_singular, (out_orig_x == '0) && (out_orig_y == '0) && (out_orig_z == '0) && !out_saturated, "singular result not cleared")
  // a clip always shows up as a range limit on some axis
  `ASSERT_IMP(a_sat_at_limit, clk, rst_n, out_valid && out_saturated, (out_orig_x == 32'sh7FFF_FFFF) || (out_orig_x == 32'sh8000_0000) || (out_orig_y == 32'sh7FFF_FFFF) || (out_orig_y == 32'sh8000_0000) || (out_orig_z == 32'sh7FFF_FFFF) || (out_orig_z == 32'sh8000_0000), "saturated flag without limit value")

endmodule

@@ tb/inverse_affine_point_transform_core_tb.sv @@
// Testbench for inverse_affine_point_transform_core: directed and random checked points.
`timescale 1ns / 1ps

module inverse_affine_point_transform_core_tb;
  import iapt_pkg::*;

  // unused register index, writes to it must be ignored
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned CycleLimit = 1_500_000;
  localparam int DrainCycles = 60;   // covers the back-end pipeline depth

  typedef struct {
    logic signed [31:0] x, y, z;
    logic sing, sat, last;
  } orig_point_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_wdata;
  logic in_valid, in_stall;
  logic signed [31:0] in_point_x, in_point_y, in_point_z;
  logic in_last_point;
  logic out_valid, out_stall;
  logic signed [31:0] out_orig_x, out_orig_y, out_orig_z;
  logic out_singular, out_saturated, out_last_out;

  inverse_affine_point_transform_core i_dut (.*);

  // predictor copy of the register file and the prepared inverse
  logic [53:0] mat_row [3];
  logic signed [31:0] offset [3];
  logic [15:0] scale;
  logic inverse_ready;
  longint adj [9];
  longint det;
  longint scaled_off [3];

  orig_point_t expected_points [$];
  int errors;
  int unsigned cycle_count;
  bit no_idle;          // burst stretches: no gaps, no stalls
  int hold_off_cycles;  // long receiver hold-off, counted down by the stall process

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint mat_entry(int r, int c);
    logic signed [17:0] e;
    e = mat_row[r % 3][18 * (c % 3) +: 18];
    return longint'(e);
  endfunction

  function automatic void prepare_inverse();
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        adj[i * 3 + j] = mat_entry(j + 1, i + 1) * mat_entry(j + 2, i + 2) -
                         mat_entry(j + 1, i + 2) * mat_entry(j + 2, i + 1);
    det = mat_entry(0, 0) * adj[0] + mat_entry(0, 1) * adj[3] + mat_entry(0, 2) * adj[6];
    for (int i = 0; i < 3; i++)
      scaled_off[i] = longint'(offset[i]) * longint'({1'b0, scale});
    inverse_ready = 1'b1;
  endfunction

  // truncating divide of the dot product by the determinant, clipped to 32 bits
  function automatic orig_point_t recover_point(logic signed [31:0] px, py, pz, logic lst);
    orig_point_t r;
    logic signed [127:0] d [3];
    logic signed [127:0] acc, q;
    logic signed [31:0] res [3];
    if (!inverse_ready) prepare_inverse();
    d[0] = 128'(longint'(px) * 65536 - scaled_off[0]);
    d[1] = 128'(longint'(py) * 65536 - scaled_off[1]);
    d[2] = 128'(longint'(pz) * 65536 - scaled_off[2]);
    r.sing = (det == 0);
    r.sat = 1'b0;
    r.last = lst;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
      if (!r.sing) begin
        acc = 128'sd0;
        for (int j = 0; j < 3; j++) acc += 128'(adj[i * 3 + j]) * d[j];
        q = acc / 128'(det);
        if (q > 128'sd2147483647) begin
          res[i] = 32'sh7fffffff; r.sat = 1'b1;
        end else if (q < -128'sd2147483648) begin
          res[i] = 32'sh80000000; r.sat = 1'b1;
        end else begin
          res[i] = q[31:0];
        end
      end
    end
    r.x = res[0]; r.y = res[1]; r.z = res[2];
    return r;
  endfunction

  // ------------------------------------------------------------------ drivers
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROW0, REG_ROW1, REG_ROW2: mat_row[idx] = val[53:0];
      REG_OFF_X: offset[0] = val[31:0];
      REG_OFF_Y: offset[1] = val[31:0];
      REG_OFF_Z: offset[2] = val[31:0];
      REG_SCALE: scale = val[15:0];
      default: ;
    endcase
    if (idx <= REG_SCALE) inverse_ready = 1'b0;
  endtask

  function automatic logic [53:0] pack_row(logic [17:0] c0, c1, c2);
    return {c2, c1, c0};
  endfunction

  task automatic load_transform(logic [53:0] r0, r1, r2, logic [31:0] vx, vy, vz,
                                logic [15:0] sc);
    write_reg(REG_ROW0, CfgW'(r0));
    write_reg(REG_ROW1, CfgW'(r1));
    write_reg(REG_ROW2, CfgW'(r2));
    write_reg(REG_OFF_X, CfgW'(vx));
    write_reg(REG_OFF_Y, CfgW'(vy));
    write_reg(REG_OFF_Z, CfgW'(vz));
    write_reg(REG_SCALE, CfgW'(sc));
  endtask

  // one point transfer; in_valid stays high afterwards for back-to-back items
  task automatic send_point(logic [31:0] px, py, pz, logic lst);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    in_last_point <= lst;
    do @(posedge clk); while (in_stall);
    expected_points.push_back(recover_point(px, py, pz, lst));
  endtask

  // block idle: all results back, then the pipeline tail
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 200) - 100;
      1: return $urandom_range(0, 2000000) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [17:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return 18'($urandom_range(0, 131071) - 65536);
      1: return 18'($urandom_range(0, 8) - 4);
      default: return 18'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (no_idle)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(0, 99) < 25) ? ($urandom_range(0, 9) != 0) : 1'b0;
  end

  function automatic void check_field(string name, logic [31:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    orig_point_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result transfer, actual x %0h y %0h z %0h",
                 $time, out_orig_x, out_orig_y, out_orig_z);
        errors++;
      end else begin
        e = expected_points.pop_front();
        check_field("orig_x", e.x, out_orig_x);
        check_field("orig_y", e.y, out_orig_y);
        check_field("orig_z", e.z, out_orig_z);
        check_field("singular", 32'(e.sing), 32'(out_singular));
        check_field("saturated", 32'(e.sat), 32'(out_saturated));
        check_field("last_out", 32'(e.last), 32'(out_last_out));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("inverse_affine_point_transform_core_tb: done, errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------- tests
  // reset values: zero matrix, so every point comes back singular
  task automatic test_reset_singular();
    send_point(32'h7fffffff, 32'h80000000, 32'h0, 1'b1);
    send_point(32'hffffffff, 32'h1, 32'h12345678, 1'b0);
    wait_idle();
  endtask

  // identity, no offset: points pass through, field extremes and last flag
  task automatic test_identity_extremes();
    load_transform(pack_row(18'd65536, 0, 0), pack_row(0, 18'd65536, 0),
                   pack_row(0, 0, 18'd65536), 0, 0, 0, 16'd1000);
    send_point(32'h7fffffff, 32'h80000000, 32'h0, 1'b0);
    send_point(32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1);
    send_point(32'haaaaaaaa, 32'h55555555, 32'h1, 1'b0);
    wait_idle();
  endtask

  // tiny and negative diagonals blow results past 32 bits
  task automatic test_saturation();
    load_transform(pack_row(18'd1, 0, 0), pack_row(0, 18'd1, 0),
                   pack_row(0, 0, 18'd1), 0, 0, 0, 16'd1);
    send_point(32'd32767, 32'd32768, -32'sd32769, 1'b0);
    send_point(32'h7fffffff, 32'h80000000, 32'd5, 1'b1);
    wait_idle();
    write_reg(REG_ROW0, CfgW'(pack_row(18'h3ffff, 0, 0)));
    send_point(32'd100000, 32'h80000000, 32'h7fffffff, 1'b0);
    wait_idle();
    load_transform(pack_row(18'h20000, 0, 0), pack_row(0, 18'h20000, 0),
                   pack_row(0, 0, 18'h1ffff), 0, 0, 0, 16'd1);
    send_point(32'h7fffffff, 32'h80000000, 32'h40000000, 1'b1);
    wait_idle();
  endtask

  // offset extremes with scale extremes, zero scale and the unused index
  task automatic test_offset_scale();
    load_transform(pack_row(18'd65536, 18'd1000, 0), pack_row(0, 18'd65536, 0),
                   pack_row(18'h3f000, 0, 18'd32768),
                   32'h7fffffff, 32'h80000000, 32'hffffffff, 16'd65535);
    send_point(32'h7fffffff, 32'h80000000, 32'h0, 1'b0);
    send_point(32'h0, 32'h0, 32'h0, 1'b1);
    wait_idle();
    write_reg(REG_SCALE, 0);
    send_point(32'd12345, -32'sd777, 32'd9, 1'b0);
    wait_idle();
    write_reg(REG_UNUSED, {CfgW{1'b1}});
    write_reg(REG_SCALE, CfgW'(1));
    send_point(32'd12345, -32'sd777, 32'd9, 1'b1);
    wait_idle();
  endtask

  task automatic load_random_transform();
    logic [53:0] r [3];
    for (int i = 0; i < 3; i++) r[i] = pack_row(rand_coef(), rand_coef(), rand_coef());
    if ($urandom_range(0, 7) == 0) r[2] = r[$urandom_range(0, 1)];  // singular
    load_transform(r[0], r[1], r[2],
                   ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000000) - 1000000,
                   $urandom, $urandom_range(0, 200000) - 100000,
                   ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1000)));
  endtask

  // receiver holds off long enough for queue and pipeline to fill and stall the input
  task automatic test_backpressure();
    load_random_transform();
    hold_off_cycles <= 300;
    repeat (80) send_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
    wait_idle();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 35; ph++) begin
      load_random_transform();
      no_idle = (ph % 5 == 2);
      for (int n = 0; n < 50; n++)
        send_point(rand_coord(), rand_coord(), rand_coord(), (n % 10 == 9));
      no_idle = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_point_x <= '0;
    in_point_y <= '0;
    in_point_z <= '0;
    in_last_point <= 1'b0;
    errors = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    hold_off_cycles = 0;
    for (int i = 0; i < 3; i++) begin
      mat_row[i] = '0;
      offset[i] = '0;
    end
    scale = ScaleReset;
    inverse_ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_singular();
    test_identity_extremes();
    test_saturation();
    test_offset_scale();
    test_backpressure();
    test_random();

    if (errors == 0)
      $display("inverse_affine_point_transform_core_tb: done, clean");
    else
      $display("inverse_affine_point_transform_core_tb: done, errors");
    $finish;
  end

endmodule
